@@ src/fixed_point_log2_log10_macros.svh @@
// Assertion macros shared by the fixed-point logarithm RTL
`ifndef FIXED_POINT_LOG2_LOG10_MACROS_SVH
`define FIXED_POINT_LOG2_LOG10_MACROS_SVH

// checked only while out of reset
`define FPLOG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FPLOG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/fplog_pkg.sv @@
// Types, constants and helpers for the fixed-point logarithm block
`default_nettype none

package fplog_pkg;

  localparam int FRAC_BITS    = 32;
  localparam int WORD_W       = 64;
  localparam int COEF_W       = 32;
  localparam int HALF_W       = WORD_W / 2;
  localparam int PROD_W       = WORD_W + COEF_W;
  localparam int MANT_W       = FRAC_BITS + 1;
  localparam int INT_W        = WORD_W - FRAC_BITS;
  localparam int LZ_W         = $clog2(WORD_W);
  localparam int NORM_STAGES  = $clog2(WORD_W);
  localparam int CNT_W        = $clog2(FRAC_BITS);
  localparam int SCALE_STAGES = 6;

  localparam logic [COEF_W-1:0] SCALE_RESET = COEF_W'(1292913986);
  localparam logic [WORD_W-1:0] MIN_WORD    = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] MAX_WORD    = ~MIN_WORD;
  localparam logic [PROD_W-1:0] RND_HALF    = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [INT_W-1:0]  IP_BIAS     = INT_W'(WORD_W - 1 - FRAC_BITS);

  typedef struct packed {
    logic              vld;
    logic              op;
    logic              nonpos;
    logic [WORD_W-1:0] word;
    logic [LZ_W-1:0]   lz;
  } norm_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ,
    ST_START,
    ST_SCALE,
    ST_HOLD
  } state_t;

  // shift tried by normalize cell n: 32, 16, ... 1
  function automatic logic [LZ_W-1:0] norm_shift(input int stage);
    return LZ_W'(WORD_W >> (stage + 1));
  endfunction

endpackage

`default_nettype wire

@@ src/fplog_norm_cell.sv @@
// One leading-zero normalize cell: tries a fixed left shift, passes result on
`default_nettype none
`include "fixed_point_log2_log10_macros.svh"

module fplog_norm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fplog_pkg::LZ_W-1:0]  shift_amt,
  input  fplog_pkg::norm_t            cell_in,
  output fplog_pkg::norm_t            cell_out
);

  logic                              vld_r;
  logic                              op_r;
  logic                              nonpos_r;
  logic [fplog_pkg::WORD_W-1:0]      word_r;
  logic [fplog_pkg::LZ_W-1:0]        lz_r;
  logic [fplog_pkg::WORD_W-1:0]      top_mask;
  logic                              top_zero;
  logic [fplog_pkg::WORD_W-1:0]      word_nxt;
  logic [fplog_pkg::LZ_W-1:0]        lz_nxt;

  assign top_mask = ~({fplog_pkg::WORD_W{1'b1}} >> shift_amt);
  assign top_zero = (cell_in.word & top_mask) == '0;
  assign word_nxt = top_zero ? (cell_in.word << shift_amt) : cell_in.word;
  assign lz_nxt   = top_zero ? (cell_in.lz + shift_amt) : cell_in.lz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cell_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= cell_in.op;
    nonpos_r <= cell_in.nonpos;
    word_r   <= word_nxt;
    lz_r     <= lz_nxt;
  end

  assign cell_out.vld    = vld_r;
  assign cell_out.op     = op_r;
  assign cell_out.nonpos = nonpos_r;
  assign cell_out.word   = word_r;
  assign cell_out.lz     = lz_r;

endmodule

`default_nettype wire

@@ src/fplog_scale.sv @@
// log10 scaling: |a| * coef in two partial products, round, shift, saturate
`default_nettype none
`include "fixed_point_log2_log10_macros.svh"

module fplog_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fplog_pkg::WORD_W-1:0]  a,
  input  logic [fplog_pkg::COEF_W-1:0]  coef,
  output logic                          done,
  output logic [fplog_pkg::WORD_W-1:0]  res
);

  logic [fplog_pkg::SCALE_STAGES-1:0] vld_r;
  logic [fplog_pkg::WORD_W-1:0]      a_r;
  logic [fplog_pkg::COEF_W-1:0]      coef_r;
  logic                              neg_r;
  logic [fplog_pkg::WORD_W-1:0]      mag_r;
  logic [fplog_pkg::HALF_W+fplog_pkg::COEF_W-1:0] plo_r;
  logic [fplog_pkg::HALF_W+fplog_pkg::COEF_W-1:0] phi_r;
  logic [fplog_pkg::PROD_W-1:0]      sum_r;
  logic [fplog_pkg::WORD_W-1:0]      res_r;
  logic [fplog_pkg::WORD_W-1:0]      q;
  logic                              hi_ovf;
  logic                              rem_nz;
  logic [fplog_pkg::WORD_W:0]        q_up;
  logic [fplog_pkg::WORD_W-1:0]      res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[fplog_pkg::SCALE_STAGES-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      coef_r <= coef;
    end
    neg_r <= a_r[fplog_pkg::WORD_W-1];
    mag_r <= a_r[fplog_pkg::WORD_W-1] ? (~a_r + 1'b1) : a_r;
    plo_r <= mag_r[fplog_pkg::HALF_W-1:0] * coef_r;
    phi_r <= mag_r[fplog_pkg::WORD_W-1:fplog_pkg::HALF_W] * coef_r;
    sum_r <= {phi_r, {fplog_pkg::HALF_W{1'b0}}} + fplog_pkg::PROD_W'(plo_r)
             + fplog_pkg::RND_HALF;
    res_r <= res_nxt;
  end

  assign q      = sum_r[fplog_pkg::FRAC_BITS +: fplog_pkg::WORD_W];
  assign hi_ovf = (sum_r >> (fplog_pkg::FRAC_BITS + fplog_pkg::WORD_W)) != '0;
  assign rem_nz = |sum_r[fplog_pkg::FRAC_BITS-1:0];
  assign q_up   = {1'b0, q} + (fplog_pkg::WORD_W+1)'(rem_nz);

  always_comb begin
    if (!neg_r) begin
      res_nxt = (hi_ovf || q[fplog_pkg::WORD_W-1]) ? fplog_pkg::MAX_WORD : q;
    end else if (hi_ovf || q_up[fplog_pkg::WORD_W]
                 || (q_up[fplog_pkg::WORD_W-1:0] > fplog_pkg::MIN_WORD)) begin
      res_nxt = fplog_pkg::MIN_WORD;
    end else begin
      res_nxt = ~q_up[fplog_pkg::WORD_W-1:0] + 1'b1;
    end
  end

  assign done = vld_r[fplog_pkg::SCALE_STAGES-1];
  assign res  = res_r;

  `FPLOG_ASSERT(a_one_in_flight, $onehot0(vld_r), "scale pipe holds more than one item")

endmodule

`default_nettype wire

@@ src/fixed_point_log2_log10.sv @@
// Top level of the fixed-point log2 / log10 unit (signed Q31.32 in and out)
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid in_ready in_op in_value     | input transfer
//   out     | out_valid out_ready out_result       | result transfer
//   cfg     | cfg_valid cfg_ready cfg_log10_scale  | coefficient write
//
// One item at a time, through 6 normalize cells, 32 passes of the 33x33 squarer and,
// for log10, the scaling pipe.
// in_ready rises again once the result sits in the output register; the next item
// may be taken while that result waits. A stalled output holds the block in its last state.
// Synchronous active-low reset; cfg_ready is always high.
`default_nettype none
`include "fixed_point_log2_log10_macros.svh"

module fixed_point_log2_log10 (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic signed [fplog_pkg::WORD_W-1:0]   in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fplog_pkg::WORD_W-1:0]   out_result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fplog_pkg::COEF_W-1:0]          cfg_log10_scale
);

  fplog_pkg::state_t                 state_r, state_nxt;
  fplog_pkg::norm_t                  chain [fplog_pkg::NORM_STAGES+1];

  logic [fplog_pkg::COEF_W-1:0]      scale_r;
  logic [fplog_pkg::MANT_W-1:0]      x_r;
  logic [fplog_pkg::FRAC_BITS-1:0]   frac_r;
  logic [fplog_pkg::INT_W-1:0]       ipart_r;
  logic [fplog_pkg::CNT_W-1:0]       cnt_r;
  logic                              nonpos_r;
  logic                              op_r;
  logic [fplog_pkg::WORD_W-1:0]      log_r;
  logic                              out_valid_r;
  logic [fplog_pkg::WORD_W-1:0]      out_result_r;

  logic                              accept;
  logic                              sq_last;
  logic [2*fplog_pkg::MANT_W-1:0]    sq;
  logic [fplog_pkg::MANT_W:0]        sq_shr;
  logic                              sq_ge;
  logic [fplog_pkg::MANT_W-1:0]      x_step;
  logic [fplog_pkg::FRAC_BITS-1:0]   frac_step;
  logic [fplog_pkg::WORD_W-1:0]      log2_val;
  logic                              sc_start;
  logic                              sc_done;
  logic [fplog_pkg::WORD_W-1:0]      sc_res;
  logic                              out_load;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= fplog_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_log10_scale;
    end
  end

  // normalize chain
  assign chain[0].vld    = accept;
  assign chain[0].op     = in_op;
  assign chain[0].nonpos = in_value[fplog_pkg::WORD_W-1] || (in_value == '0);
  assign chain[0].word   = $unsigned(in_value);
  assign chain[0].lz     = '0;

  for (genvar g = 0; g < fplog_pkg::NORM_STAGES; g++) begin : g_norm
    fplog_norm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_amt (fplog_pkg::norm_shift(g)),
      .cell_in   (chain[g]),
      .cell_out  (chain[g+1])
    );
  end

  // squaring step
  assign sq        = x_r * x_r;
  assign sq_shr    = sq[fplog_pkg::FRAC_BITS +: fplog_pkg::MANT_W+1];
  assign sq_ge     = sq_shr[fplog_pkg::MANT_W];
  assign x_step    = sq_ge ? sq_shr[fplog_pkg::MANT_W:1] : sq_shr[fplog_pkg::MANT_W-1:0];
  assign frac_step = {frac_r[fplog_pkg::FRAC_BITS-2:0], sq_ge};
  assign sq_last   = cnt_r == fplog_pkg::CNT_W'(fplog_pkg::FRAC_BITS - 1);
  assign log2_val  = nonpos_r ? fplog_pkg::MIN_WORD : {ipart_r, frac_step};

  fplog_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .a     (log_r),
    .coef  (scale_r),
    .done  (sc_done),
    .res   (sc_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fplog_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fplog_pkg::ST_IDLE:  if (accept) state_nxt = fplog_pkg::ST_NORM;
      fplog_pkg::ST_NORM:  if (chain[fplog_pkg::NORM_STAGES].vld) state_nxt = fplog_pkg::ST_SQ;
      fplog_pkg::ST_SQ: begin
        if (sq_last) state_nxt = op_r ? fplog_pkg::ST_START : fplog_pkg::ST_HOLD;
      end
      fplog_pkg::ST_START: state_nxt = fplog_pkg::ST_SCALE;
      fplog_pkg::ST_SCALE: if (sc_done) state_nxt = fplog_pkg::ST_HOLD;
      fplog_pkg::ST_HOLD:  if (out_load) state_nxt = fplog_pkg::ST_IDLE;
      default:             state_nxt = fplog_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    sc_start = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      fplog_pkg::ST_IDLE:  in_ready = 1'b1;
      fplog_pkg::ST_START: sc_start = 1'b1;
      fplog_pkg::ST_HOLD:  out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == fplog_pkg::ST_NORM && chain[fplog_pkg::NORM_STAGES].vld) begin
      x_r      <= chain[fplog_pkg::NORM_STAGES].word[fplog_pkg::WORD_W-1 -: fplog_pkg::MANT_W];
      ipart_r  <= fplog_pkg::IP_BIAS - fplog_pkg::INT_W'(chain[fplog_pkg::NORM_STAGES].lz);
      nonpos_r <= chain[fplog_pkg::NORM_STAGES].nonpos;
      op_r     <= chain[fplog_pkg::NORM_STAGES].op;
      cnt_r    <= '0;
    end else if (state_r == fplog_pkg::ST_SQ) begin
      x_r    <= x_step;
      frac_r <= frac_step;
      cnt_r  <= cnt_r + 1'b1;
      if (sq_last) log_r <= log2_val;
    end else if (state_r == fplog_pkg::ST_SCALE && sc_done) begin
      log_r <= sc_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_result_r <= log_r;
  end

  assign out_valid  = out_valid_r;
  assign out_result = $signed(out_result_r);

  `FPLOG_ASSERT(a_hold_stall, (state_r == fplog_pkg::ST_HOLD && out_valid_r && !out_ready) |=> (state_r == fplog_pkg::ST_HOLD), "result dropped while output stalled")
  `FPLOG_ASSERT(a_scale_done, sc_done |-> (state_r == fplog_pkg::ST_SCALE), "scale result outside scale state")
  `FPLOG_ASSERT(a_norm_done, chain[fplog_pkg::NORM_STAGES].vld |-> (state_r == fplog_pkg::ST_NORM), "normalize output outside norm state")
  `FPLOG_ASSERT_RST(a_reset, !rst_n |=> (in_ready && !out_valid), "block not idle after reset")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for fixed_point_log2_log10: directed table and random operands
`timescale 1ns / 100ps

module tb;

  localparam logic OP_LOG2  = 1'b0;
  localparam logic OP_LOG10 = 1'b1;
  localparam int   RAND_PER_SCALE = 430;
  localparam int   STALL_LIMIT    = 4000;
  localparam int   SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic                         op;
    logic [fplog_pkg::WORD_W-1:0] value;
    logic                         known;
    logic [fplog_pkg::WORD_W-1:0] want;
  } log_case_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_op = 1'b0;
  logic signed [fplog_pkg::WORD_W-1:0] in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [fplog_pkg::WORD_W-1:0] out_result;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [fplog_pkg::COEF_W-1:0]        cfg_log10_scale = '0;

  logic [fplog_pkg::COEF_W-1:0] scale_reg = fplog_pkg::SCALE_RESET;
  logic [fplog_pkg::WORD_W-1:0] pending_logs[$];
  logic [fplog_pkg::WORD_W-1:0] head_log;
  int                           in_idle_pct = 0;
  int                           out_idle_pct = 0;
  int                           mismatches = 0;
  int                           stall_cycles = 0;

  // exact results typed in where they are plain; the rest go through the predictor
  log_case_t directed_cases [22] = '{
    '{OP_LOG2,  64'h0000_0001_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
    '{OP_LOG10, 64'h0000_0001_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
    '{OP_LOG2,  64'h0000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000},
    '{OP_LOG2,  64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000},
    '{OP_LOG2,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0000},
    '{OP_LOG10, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{OP_LOG10, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
    '{OP_LOG2,  64'h0000_0000_0000_0001, 1'b1, 64'hFFFF_FFE0_0000_0000},
    '{OP_LOG10, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
    '{OP_LOG2,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{OP_LOG10, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{OP_LOG2,  64'h0000_0002_0000_0000, 1'b1, 64'h0000_0001_0000_0000},
    '{OP_LOG2,  64'h0000_0000_8000_0000, 1'b1, 64'hFFFF_FFFF_0000_0000},
    '{OP_LOG2,  64'h4000_0000_0000_0000, 1'b1, 64'h0000_001E_0000_0000},
    '{OP_LOG10, 64'h4000_0000_0000_0000, 1'b0, 64'h0},
    '{OP_LOG2,  64'h0000_0001_8000_0000, 1'b0, 64'h0},
    '{OP_LOG10, 64'h0000_000A_0000_0000, 1'b0, 64'h0},
    '{OP_LOG2,  64'h0000_0001_FFFF_FFFF, 1'b0, 64'h0},
    '{OP_LOG10, 64'h0000_0000_0000_0003, 1'b0, 64'h0},
    '{OP_LOG2,  64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{OP_LOG10, 64'h2AAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
    '{OP_LOG10, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'h0}
  };

  fixed_point_log2_log10 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result      (out_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_log10_scale (cfg_log10_scale)
  );

  always #4 clk = ~clk;

  function automatic logic [fplog_pkg::WORD_W-1:0] bin_log2(
      input logic [fplog_pkg::WORD_W-1:0] x);
    logic [fplog_pkg::WORD_W-1:0]        m;
    logic [fplog_pkg::WORD_W-1:0]        res;
    logic [2*fplog_pkg::WORD_W-1:0]      sq;
    logic signed [fplog_pkg::WORD_W-1:0] ip;
    int                                  msb;
    if (x[fplog_pkg::WORD_W-1] || x == '0) return fplog_pkg::MIN_WORD;
    msb = fplog_pkg::WORD_W - 2;
    while (!x[msb]) msb--;
    if (msb >= fplog_pkg::FRAC_BITS) begin
      m = x >> (msb - fplog_pkg::FRAC_BITS);
    end else begin
      m = x << (fplog_pkg::FRAC_BITS - msb);
    end
    ip  = msb - fplog_pkg::FRAC_BITS;
    res = ip << fplog_pkg::FRAC_BITS;
    for (int i = 1; i <= fplog_pkg::FRAC_BITS; i++) begin
      sq = {{fplog_pkg::WORD_W{1'b0}}, m} * {{fplog_pkg::WORD_W{1'b0}}, m};
      m  = sq[fplog_pkg::FRAC_BITS +: fplog_pkg::WORD_W];
      if (m >= (fplog_pkg::WORD_W'(2) << fplog_pkg::FRAC_BITS)) begin
        m >>= 1;
        res[fplog_pkg::FRAC_BITS-i] = 1'b1;
      end
    end
    return res;
  endfunction

  // signed log2 times unsigned coefficient, add half, floor shift; a negative result rounds its magnitude up; clamp
  function automatic logic [fplog_pkg::WORD_W-1:0] scale_log(
      input logic [fplog_pkg::WORD_W-1:0] a,
      input logic [fplog_pkg::COEF_W-1:0] b);
    logic                           neg;
    logic [fplog_pkg::WORD_W-1:0]   mag;
    logic [2*fplog_pkg::WORD_W-1:0] p;
    logic [2*fplog_pkg::WORD_W-1:0] q;
    neg = a[fplog_pkg::WORD_W-1];
    mag = neg ? -a : a;
    p   = (2*fplog_pkg::WORD_W)'(mag) * (2*fplog_pkg::WORD_W)'(b)
          + ((2*fplog_pkg::WORD_W)'(1) << (fplog_pkg::FRAC_BITS - 1));
    q   = p >> fplog_pkg::FRAC_BITS;
    if (!neg) begin
      return (q > (2*fplog_pkg::WORD_W)'(fplog_pkg::MAX_WORD)) ?
             fplog_pkg::MAX_WORD : q[fplog_pkg::WORD_W-1:0];
    end
    if (p[fplog_pkg::FRAC_BITS-1:0] != '0) q++;
    return (q > (2*fplog_pkg::WORD_W)'(fplog_pkg::MIN_WORD)) ?
           fplog_pkg::MIN_WORD : -q[fplog_pkg::WORD_W-1:0];
  endfunction

  function automatic logic [fplog_pkg::WORD_W-1:0] predict_log(
      input logic op, input logic [fplog_pkg::WORD_W-1:0] v);
    logic [fplog_pkg::WORD_W-1:0] r;
    r = bin_log2(v);
    if (op == OP_LOG10) r = scale_log(r, scale_reg);
    return r;
  endfunction

  function automatic logic [fplog_pkg::WORD_W-1:0] random_operand();
    logic [fplog_pkg::WORD_W-1:0] v;
    int                           k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v[fplog_pkg::WORD_W-1] = 1'b1;
      1: v = fplog_pkg::WORD_W'(1) << $urandom_range(0, fplog_pkg::WORD_W - 2);
      2: begin
        k = $urandom_range(1, fplog_pkg::WORD_W - 2);
        v = (fplog_pkg::WORD_W'(1) << k) + fplog_pkg::WORD_W'($urandom_range(0, 2))
            - fplog_pkg::WORD_W'(1);
      end
      3: v = fplog_pkg::WORD_W'($urandom_range(0, 1000));
      default: begin
        v[fplog_pkg::WORD_W-1] = 1'b0;
        v = v >> $urandom_range(0, fplog_pkg::WORD_W - 2);
        if (v == '0) v = fplog_pkg::WORD_W'(1);
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic drive_item(input logic op, input logic [fplog_pkg::WORD_W-1:0] v,
                            input logic known,
                            input logic [fplog_pkg::WORD_W-1:0] want);
    logic [fplog_pkg::WORD_W-1:0] exp_log;
    exp_log = known ? want : predict_log(op, v);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    pending_logs.push_back(exp_log);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_logs.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(input logic [fplog_pkg::COEF_W-1:0] v);
    cfg_valid       <= 1'b1;
    cfg_log10_scale <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_reg = v;
  endtask

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      drive_item(logic'($urandom_range(0, 1)), random_operand(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_logs.size() == 0) begin
        report_mismatch($sformatf("result %h with none expected", out_result));
      end else begin
        head_log = pending_logs.pop_front();
        if (out_result !== head_log)
          report_mismatch($sformatf("result %h, expected %h", out_result, head_log));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && pending_logs.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 17;
    out_idle_pct = 77;
    foreach (directed_cases[i]) begin
      drive_item(directed_cases[i].op, directed_cases[i].value,
                 directed_cases[i].known, directed_cases[i].want);
    end
    drain();
    write_scale('1);
    random_items(RAND_PER_SCALE);
    drain();

    in_idle_pct  = 77;
    out_idle_pct = 17;
    write_scale('0);
    random_items(RAND_PER_SCALE);
    drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_scale($urandom);
    random_items(RAND_PER_SCALE);
    drain();
    write_scale(fplog_pkg::SCALE_RESET);
    random_items(RAND_PER_SCALE);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
